FILE: rtl/core/lzid_pkg.sv
// shared constants and types for the inverted-literal lzss decoder
package lzid_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int WIN_AW      = $clog2(WINDOW_SIZE);
  localparam int LEN_W       = 5;

  typedef logic [WIN_AW-1:0] win_addr_t;

  localparam win_addr_t        WRITE_START = WIN_AW'(12'hfee);
  localparam logic [LEN_W-1:0] MIN_MATCH   = LEN_W'(3);
  localparam logic [3:0]       FLAG_TOKENS = 4'd8;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_HIGH  = 2'd2
  } phase_t;

endpackage

FILE: rtl/core/lzss_inverted_literal_decoder.sv
// lzss decoder with inverted literals over a 4096-byte history window
//
// compressed bytes enter on the s_axis channel, one per beat; tuser marks the
// first byte of a stream, which restarts the window, write pointer, counter and
// token parser. decompressed bytes leave on m_axis with the running byte count
// and tlast on the final byte produced by one input beat. cfg_we/cfg_wdata set
// the output limit, after which the stream is ignored until the next start.
// a flag byte or the first match byte yields nothing; a literal is registered
// as its beat is taken. a match is entered, its first window read is issued,
// then it yields one output byte per cycle while m_axis is not stalled (3 to
// 18 bytes), paced by the single read port of the window memory. the window is
// never swept: an entry counts as zero unless the fill count of the current
// stream shows it was written, so a stream start needs no clearing pass. reset
// restores all parser state and sets the limit to all ones. when m_axis stalls
// the output register holds its beat and the input side waits.
module lzss_inverted_literal_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tuser,   // stream_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte [7:0], total_count [39:8]
  output logic        m_axis_tlast,   // run_last
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import lzid_pkg::*;

  typedef enum logic {ST_IDLE, ST_MATCH} state_t;

  state_t     state;
  phase_t     phase;
  logic [7:0] flags;
  logic [3:0] bits_left;
  logic [7:0] low_byte;
  logic [31:0] count;
  logic       halted;
  win_addr_t  wp;
  logic [31:0] limit;

  win_addr_t        m_pos;
  logic [LEN_W-1:0] left_rd;
  logic [LEN_W-1:0] left_em;
  logic             rd_pend;
  logic             rd_fwd;
  logic             rd_valid;
  logic [7:0]       rd_fwd_data;
  logic [7:0]       rdata;

  logic [7:0]  out_byte;
  logic [31:0] out_count;

  logic [7:0] mem [WINDOW_SIZE];

  logic        out_free, in_fire, ss;
  logic [31:0] e_count;
  logic        e_halt;
  phase_t      e_phase;
  logic [7:0]  e_flags;
  logic [3:0]  e_bits;
  win_addr_t   e_wp;
  logic        lit_emit;
  logic [7:0]  m_byte;
  logic        m_emit, m_halt, m_issue, m_last;
  logic        we;
  win_addr_t   waddr;
  logic [7:0]  wdata;
  logic [7:0]  tf_flags;
  logic [3:0]  tf_bits, td_bits;
  phase_t      td_phase;
  win_addr_t   rd_off;
  logic        rd_valid_next;
  logic [31:0] m_count_inc;

  assign m_axis_tdata = {out_count, out_byte};

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign ss            = s_axis_tuser;

  // state as seen after an optional stream restart
  assign e_count = ss ? 32'd0 : count;
  assign e_halt  = ss ? 1'b0 : halted;
  assign e_phase = ss ? PH_FLAG : phase;
  assign e_flags = ss ? 8'd0 : flags;
  assign e_bits  = ss ? 4'd0 : bits_left;
  assign e_wp    = ss ? WRITE_START : wp;

  assign lit_emit = in_fire && !e_halt && (e_phase == PH_TOKEN) && e_flags[0]
                    && (e_count < limit);

  assign m_byte      = rd_fwd ? rd_fwd_data : (rd_valid ? rdata : 8'h00);
  assign m_emit      = (state == ST_MATCH) && rd_pend && out_free && (count < limit);
  assign m_halt      = (state == ST_MATCH) && rd_pend && !(count < limit);
  assign m_issue     = (state == ST_MATCH) && (left_rd != '0) && (!rd_pend || m_emit);
  assign m_count_inc = count + 32'd1;
  assign m_last      = (left_em == LEN_W'(1)) || (m_count_inc == limit);

  // entries outside the span written in this stream read as zero
  assign rd_off        = m_pos - WRITE_START;
  assign rd_valid_next = (count[31:WIN_AW] != '0) || (rd_off < count[WIN_AW-1:0]);

  assign we    = lit_emit || m_emit;
  assign waddr = lit_emit ? e_wp : wp;
  assign wdata = lit_emit ? ~s_axis_tdata : m_byte;

  assign tf_flags = (state == ST_IDLE) ? e_flags : flags;
  assign tf_bits  = (state == ST_IDLE) ? e_bits : bits_left;
  assign td_bits  = tf_bits - {3'b000, (tf_bits != 4'd0)};
  assign td_phase = (td_bits != 4'd0) ? PH_TOKEN : PH_FLAG;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (m_issue) begin
      rdata <= mem[m_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_FLAG;
      flags         <= '0;
      bits_left     <= '0;
      low_byte      <= '0;
      count         <= '0;
      halted        <= 1'b0;
      wp            <= WRITE_START;
      limit         <= '1;
      m_axis_tvalid <= 1'b0;
      rd_pend       <= 1'b0;
      left_rd       <= '0;
      left_em       <= '0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            count     <= e_count;
            halted    <= e_halt;
            phase     <= e_phase;
            flags     <= e_flags;
            bits_left <= e_bits;
            wp        <= e_wp;
            if (ss) begin
              low_byte <= '0;
            end
            if (!e_halt) begin
              case (e_phase)
                PH_TOKEN: begin
                  if (e_flags[0]) begin
                    if (lit_emit) begin
                      m_axis_tvalid <= 1'b1;
                      out_byte      <= ~s_axis_tdata;
                      out_count     <= e_count + 32'd1;
                      m_axis_tlast  <= 1'b1;
                      count         <= e_count + 32'd1;
                      wp            <= e_wp + WIN_AW'(1);
                      flags         <= tf_flags >> 1;
                      bits_left     <= td_bits;
                      phase         <= td_phase;
                    end else begin
                      halted <= 1'b1;
                    end
                  end else begin
                    low_byte <= s_axis_tdata;
                    phase    <= PH_HIGH;
                  end
                end
                PH_HIGH: begin
                  m_pos   <= {s_axis_tdata[7:4], low_byte};
                  left_rd <= LEN_W'(s_axis_tdata[3:0]) + MIN_MATCH;
                  left_em <= LEN_W'(s_axis_tdata[3:0]) + MIN_MATCH;
                  rd_pend <= 1'b0;
                  state   <= ST_MATCH;
                end
                default: begin
                  flags     <= s_axis_tdata;
                  bits_left <= FLAG_TOKENS;
                  phase     <= PH_TOKEN;
                end
              endcase
            end
          end
        end
        ST_MATCH: begin
          if (m_halt) begin
            halted  <= 1'b1;
            rd_pend <= 1'b0;
            state   <= ST_IDLE;
          end else begin
            if (m_issue) begin
              m_pos       <= m_pos + WIN_AW'(1);
              left_rd     <= left_rd - LEN_W'(1);
              rd_valid    <= rd_valid_next;
              rd_fwd      <= m_emit && (m_pos == wp);
              rd_fwd_data <= m_byte;
              rd_pend     <= 1'b1;
            end else if (m_emit) begin
              rd_pend <= 1'b0;
            end
            if (m_emit) begin
              m_axis_tvalid <= 1'b1;
              out_byte      <= m_byte;
              out_count     <= m_count_inc;
              m_axis_tlast  <= m_last;
              count         <= m_count_inc;
              wp            <= wp + WIN_AW'(1);
              left_em       <= left_em - LEN_W'(1);
              if (left_em == LEN_W'(1)) begin
                flags     <= tf_flags >> 1;
                bits_left <= td_bits;
                phase     <= td_phase;
                state     <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: test/tb_lzss_inverted_literal_decoder.sv
// self-checking testbench for the inverted-literal lzss decoder with its own decoding model
module tb_lzss_inverted_literal_decoder;
  import lzid_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        typed;
    logic [7:0]  want_byte;
    logic [31:0] want_total;
  } comp_beat_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] total;
  } plain_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // in_byte
  logic        s_axis_tuser;   // stream_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // out_byte [7:0], total_count [39:8]
  logic        m_axis_tlast;   // run_last
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  lzss_inverted_literal_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // decoder model state
  logic [7:0]  hist [WINDOW_SIZE];
  win_addr_t   wr_pos;
  logic [7:0]  flags;
  logic [3:0]  tokens_left;
  phase_t      phase;
  logic [7:0]  low_byte;
  logic [31:0] emitted;
  logic        stopped;
  logic [31:0] byte_limit;

  comp_beat_t  comp_q[$];
  plain_beat_t plain_q[$];
  comp_beat_t  bus_beat;
  int          errors = 0;
  int          burst_left;
  int          gap_left;
  logic [5:0]  stall_step;
  logic [15:0] stall_mask;
  int          idle_cycles = 0;

  // directed stream: literal extremes, window wrap, long match, truncated match
  comp_beat_t directed_rows [23] = '{
    '{8'hff, 1'b1, 1'b0, 8'h00, 32'd0},
    '{8'h00, 1'b0, 1'b1, 8'hff, 32'd1},
    '{8'hff, 1'b0, 1'b1, 8'h00, 32'd2},
    '{8'h5a, 1'b0, 1'b1, 8'ha5, 32'd3},
    '{8'h01, 1'b0, 1'b1, 8'hfe, 32'd4},
    '{8'h80, 1'b0, 1'b1, 8'h7f, 32'd5},
    '{8'h7f, 1'b0, 1'b1, 8'h80, 32'd6},
    '{8'hc3, 1'b0, 1'b1, 8'h3c, 32'd7},
    '{8'h0f, 1'b0, 1'b1, 8'hf0, 32'd8},
    '{8'h00, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'hee, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'hff, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'hff, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'hf0, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'h34, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'h5a, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'h12, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'h02, 1'b1, 1'b0, 8'h00, 32'd0},
    '{8'hee, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 32'd0},
    '{8'h55, 1'b0, 1'b1, 8'haa, 32'd4}
  };

  function automatic void restart_stream();
    foreach (hist[i]) hist[i] = 8'h00;
    wr_pos      = WRITE_START;
    flags       = 8'h00;
    tokens_left = 4'd0;
    phase       = PH_FLAG;
    low_byte    = 8'h00;
    emitted     = 32'd0;
    stopped     = 1'b0;
  endfunction

  function automatic logic emit_plain(logic [7:0] b);
    if (emitted >= byte_limit) begin
      stopped = 1'b1;
      return 1'b0;
    end
    hist[wr_pos] = b;
    wr_pos       = wr_pos + 1'b1;
    emitted      = emitted + 1;
    plain_q.push_back('{b, 1'b0, emitted});
    return 1'b1;
  endfunction

  function automatic void token_finished();
    flags = flags >> 1;
    if (tokens_left != 0) tokens_left = tokens_left - 1'b1;
    phase = (tokens_left != 0) ? PH_TOKEN : PH_FLAG;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic start);
    int          base = plain_q.size();
    win_addr_t   pos;
    int          len;
    logic        ok;
    plain_beat_t tail;
    if (start) restart_stream();
    if (stopped) return;
    case (phase)
      PH_TOKEN: begin
        if (flags[0]) begin
          if (emit_plain(~b)) token_finished();
        end else begin
          low_byte = b;
          phase    = PH_HIGH;
        end
      end
      PH_HIGH: begin
        pos = {b[7:4], low_byte};
        len = int'(b[3:0]) + int'(MIN_MATCH);
        ok  = 1'b1;
        for (int i = 0; i < len && ok; i++) ok = emit_plain(hist[win_addr_t'(pos + i)]);
        if (ok) token_finished();
      end
      default: begin
        flags       = b;
        tokens_left = FLAG_TOKENS;
        phase       = PH_TOKEN;
      end
    endcase
    if (plain_q.size() > base) begin
      tail      = plain_q.pop_back();
      tail.last = 1'b1;
      plain_q.push_back(tail);
    end
  endfunction

  task automatic accept_beat(comp_beat_t bt);
    int base = plain_q.size();
    decode_byte(bt.data, bt.start);
    if (bt.typed) begin
      while (plain_q.size() > base) void'(plain_q.pop_back());
      plain_q.push_back('{bt.want_byte, 1'b1, bt.want_total});
    end
  endtask

  function automatic void note_error(string what, logic [39:0] want, logic [39:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
  endfunction

  task automatic check_plain();
    plain_beat_t want;
    if (plain_q.size() == 0) begin
      note_error("unexpected beat, data", 40'h0, m_axis_tdata);
      return;
    end
    want = plain_q.pop_front();
    if (m_axis_tdata[7:0] !== want.data)
      note_error("out_byte", 40'(want.data), 40'(m_axis_tdata[7:0]));
    if (m_axis_tdata[39:8] !== want.total)
      note_error("total_count", 40'(want.total), 40'(m_axis_tdata[39:8]));
    if (m_axis_tlast !== want.last)
      note_error("run_last", 40'(want.last), 40'(m_axis_tlast));
  endtask

  function automatic void add_beat(logic [7:0] d, logic start);
    comp_q.push_back('{d, start, 1'b0, 8'h00, 32'd0});
  endfunction

  task automatic queue_random(int n_items, logic fresh);
    logic [7:0] fl;
    logic       first;
    win_addr_t  pos;
    logic [3:0] len;
    int         added;
    first = fresh;
    added = 0;
    while (added < n_items) begin
      case ($urandom_range(0, 15))
        0: begin
          add_beat(8'($urandom), $urandom_range(0, 3) == 0);
          added++;
        end
        1: begin
          // match that a following stream start usually cuts off
          add_beat(8'($urandom) & 8'hfe, first);
          add_beat(8'($urandom), 1'b0);
          added += 2;
          first = 1'b1;
        end
        default: begin
          fl = 8'($urandom);
          add_beat(fl, first);
          added++;
          first = ($urandom_range(0, 9) == 0);
          for (int k = 0; k < 8; k++) begin
            if (fl[k]) begin
              add_beat(8'($urandom), 1'b0);
              added++;
            end else begin
              pos = $urandom_range(0, 1) ? WRITE_START + 12'($urandom_range(0, 160))
                                         : 12'($urandom);
              len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(7, 15))
                                                : 4'($urandom_range(0, 6));
              add_beat(pos[7:0], 1'b0);
              add_beat({pos[11:8], len}, 1'b0);
              added += 2;
            end
          end
        end
      endcase
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (comp_q.size() != 0 || s_axis_tvalid || plain_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    byte_limit = v;
    @(negedge clk);
  endtask

  // sender: bursts of beats with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tuser  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) accept_beat(bus_beat);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (comp_q.size() > 0) begin
          bus_beat = comp_q.pop_front();
          s_axis_tdata  <= bus_beat.data;
          s_axis_tuser  <= bus_beat.start;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready follows a mask that is redrawn when the step counter wraps
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_step    <= 6'd0;
      stall_mask    <= 16'hffff;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_plain();
      stall_step    <= stall_step + 1'b1;
      m_axis_tready <= stall_mask[stall_step[3:0]];
      if (stall_step == 6'd63) begin
        case ($urandom_range(0, 3))
          0: stall_mask <= 16'hffff;
          1: stall_mask <= 16'($urandom) | 16'h0001;
          2: stall_mask <= 16'h8001;
          default: stall_mask <= 16'haaaa;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [31:0] limits [6];
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 32'd0;
    restart_stream();
    byte_limit = 32'hffff_ffff;
    limits = '{32'd0, 32'd1, 32'd37, 32'($urandom_range(2, 150)), 32'hffff_ffff,
               32'($urandom)};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i]) comp_q.push_back(directed_rows[i]);
    drain();
    foreach (limits[p]) begin
      write_limit(limits[p]);
      queue_random((limits[p] == 0) ? 8 : 42, p != 5);
      drain();
    end
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lzid_pkg.sv
rtl/core/lzss_inverted_literal_decoder.sv
test/tb_lzss_inverted_literal_decoder.sv
